// ===== sv/npc_pkg.sv =====
// Shared types, constants and helpers for the nearest palette colour pair core.
package npc_pkg;

    // Palette geometry
    localparam int PALETTE_SIZE = 8;
    localparam int IDX_W        = 3;
    localparam int COMP_W       = 10;
    localparam int SQ_W         = 2 * COMP_W;
    localparam int DIST_W       = SQ_W + 2;

    // floor(c * 392 / 100) == (c * 513814) >> 17 for every 8-bit c
    localparam int          SCALE_PROD_W = 27;
    localparam int          SCALE_SHIFT  = 17;
    localparam logic [26:0] SCALE_MUL    = 27'd513814;

    // Bold threshold on the raw foreground components
    localparam logic [7:0] BOLD_LIMIT = 8'd128;

    typedef logic [COMP_W-1:0] comp_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;

    // Packing matches the register: red 9:0, green 19:10, blue 29:20
    typedef struct packed {
        comp_t blue;
        comp_t green;
        comp_t red;
    } color_t;

    // Candidate in the minimum search
    typedef struct packed {
        dist_t score;
        idx_t  idx;
    } cand_t;

    // Stage enables handed to each distance lane
    typedef struct packed {
        logic sq_en;
        logic sum_en;
    } lane_ctrl_t;

    // Lower distance wins; on a tie the first (lower index) candidate is kept
    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        cand_t r;
        r = (b.score < a.score) ? b : a;
        return r;
    endfunction

endpackage

// ===== sv/npc_lane.sv =====
// One distance lane: squared distance from both cell colours to one palette entry.
module npc_lane
(
    input  logic                clk,
    input  npc_pkg::lane_ctrl_t ctrl,
    input  npc_pkg::color_t     entry,
    input  npc_pkg::color_t     fore,
    input  npc_pkg::color_t     back,
    output npc_pkg::dist_t      fore_dist,
    output npc_pkg::dist_t      back_dist
);

    logic [npc_pkg::SQ_W-1:0] fore_sq_reg [3];
    logic [npc_pkg::SQ_W-1:0] fore_sq_next [3];
    logic [npc_pkg::SQ_W-1:0] back_sq_reg [3];
    logic [npc_pkg::SQ_W-1:0] back_sq_next [3];
    npc_pkg::dist_t           fore_dist_reg;
    npc_pkg::dist_t           back_dist_reg;

    function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
        input npc_pkg::comp_t a,
        input npc_pkg::comp_t b
    );
        npc_pkg::comp_t d;
        d = (a > b) ? (a - b) : (b - a);
        return {{npc_pkg::COMP_W{1'b0}}, d} * {{npc_pkg::COMP_W{1'b0}}, d};
    endfunction

    // Squares per component
    always_comb
    begin
        fore_sq_next[0] = sq_diff(fore.red,   entry.red);
        fore_sq_next[1] = sq_diff(fore.green, entry.green);
        fore_sq_next[2] = sq_diff(fore.blue,  entry.blue);
        back_sq_next[0] = sq_diff(back.red,   entry.red);
        back_sq_next[1] = sq_diff(back.green, entry.green);
        back_sq_next[2] = sq_diff(back.blue,  entry.blue);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            fore_sq_reg <= fore_sq_next;
            back_sq_reg <= back_sq_next;
        end
    end

    // Sum of the three squares
    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            fore_dist_reg <= {2'b00, fore_sq_reg[0]} + {2'b00, fore_sq_reg[1]}
                           + {2'b00, fore_sq_reg[2]};
            back_dist_reg <= {2'b00, back_sq_reg[0]} + {2'b00, back_sq_reg[1]}
                           + {2'b00, back_sq_reg[2]};
        end
    end

    assign fore_dist = fore_dist_reg;
    assign back_dist = back_dist_reg;

endmodule

// ===== sv/npc_merge.sv =====
// Merging stage: registered minimum tree over the lane distances.
module npc_merge
(
    input  logic           clk,
    input  logic           en,
    input  npc_pkg::dist_t fore_dist [npc_pkg::PALETTE_SIZE],
    input  npc_pkg::dist_t back_dist [npc_pkg::PALETTE_SIZE],
    output npc_pkg::idx_t  fore_index,
    output npc_pkg::idx_t  back_index
);

    npc_pkg::cand_t fore_half_reg [2];
    npc_pkg::cand_t fore_half_next [2];
    npc_pkg::cand_t back_half_reg [2];
    npc_pkg::cand_t back_half_next [2];
    npc_pkg::cand_t fore_leaf [npc_pkg::PALETTE_SIZE];
    npc_pkg::cand_t back_leaf [npc_pkg::PALETTE_SIZE];
    npc_pkg::cand_t fore_pair [4];
    npc_pkg::cand_t back_pair [4];
    npc_pkg::cand_t fore_win;
    npc_pkg::cand_t back_win;

    // Two tree levels down to one winner per half
    always_comb
    begin
        for (int i = 0; i < npc_pkg::PALETTE_SIZE; i++)
        begin
            fore_leaf[i] = '{score: fore_dist[i], idx: npc_pkg::idx_t'(i)};
            back_leaf[i] = '{score: back_dist[i], idx: npc_pkg::idx_t'(i)};
        end
        for (int i = 0; i < 4; i++)
        begin
            fore_pair[i] = npc_pkg::pick_min(fore_leaf[2*i], fore_leaf[2*i+1]);
            back_pair[i] = npc_pkg::pick_min(back_leaf[2*i], back_leaf[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            fore_half_next[i] = npc_pkg::pick_min(fore_pair[2*i], fore_pair[2*i+1]);
            back_half_next[i] = npc_pkg::pick_min(back_pair[2*i], back_pair[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fore_half_reg <= fore_half_next;
            back_half_reg <= back_half_next;
        end
    end

    // Final level; registered by the output stage
    always_comb
    begin
        fore_win = npc_pkg::pick_min(fore_half_reg[0], fore_half_reg[1]);
        back_win = npc_pkg::pick_min(back_half_reg[0], back_half_reg[1]);
    end

    assign fore_index = fore_win.idx;
    assign back_index = back_win.idx;

endmodule

// ===== sv/nearest_palette_color_pair_core.sv =====
// Top level: palette registers, colour scaling, eight distance lanes and result register.
//
//  port group   dir  beat contents
//  s_*          in   one character cell: fg and bg RGB, 8 bits each
//  m_*          out  pair index, fg index, bg index, bold flag
//  p*           cfg  eight 30-bit palette entries at byte address 4*i
//
//  One cell per clock unless the output stalls; a beat passes five registered stages:
//  scale, square, sum, tree half, and final compare into the output register.
//  A stalled output backs up stage by stage: empty stages still take beats,
//  and s_tready drops once all five stages hold one.
//  rst_n clears all valid bits and the palette to zero.
module nearest_palette_color_pair_core
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input cell stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // fore_red[7:0], fore_green[15:8], fore_blue[23:16],
    // back_red[31:24], back_green[39:32], back_blue[47:40]
    input  logic [47:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // pair_index[5:0], fore_index[8:6], back_index[11:9], bold[12], zero[15:13]
    output logic [15:0] m_tdata
);

    localparam int N = npc_pkg::PALETTE_SIZE;

    npc_pkg::color_t     palette_reg [N];
    npc_pkg::color_t     fore_s1_reg;
    npc_pkg::color_t     back_s1_reg;
    npc_pkg::color_t     fore_s1_next;
    npc_pkg::color_t     back_s1_next;
    logic [3:0]          bold_pipe_reg;
    logic                bold_next;
    logic [3:0]          valid_pipe_reg;
    logic [4:0]          en;
    logic                out_valid_reg;
    logic [12:0]         out_data_reg;
    logic                cfg_write;
    npc_pkg::lane_ctrl_t lane_ctrl;
    npc_pkg::dist_t      fore_dist [N];
    npc_pkg::dist_t      back_dist [N];
    npc_pkg::idx_t       fore_index;
    npc_pkg::idx_t       back_index;

    function automatic npc_pkg::comp_t scale(input logic [7:0] c);
        logic [npc_pkg::SCALE_PROD_W-1:0] p;
        p = {{(npc_pkg::SCALE_PROD_W-8){1'b0}}, c} * npc_pkg::SCALE_MUL;
        return p[npc_pkg::SCALE_SHIFT +: npc_pkg::COMP_W];
    endfunction

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = {2'b00, palette_reg[paddr[4:2]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                palette_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            palette_reg[paddr[4:2]] <= pwdata[29:0];
        end
    end

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[4] = !out_valid_reg || m_tready;
        for (int k = 3; k >= 0; k--)
            en[k] = !valid_pipe_reg[k] || en[k+1];
    end

    assign s_tready         = en[0];
    assign lane_ctrl.sq_en  = en[1];
    assign lane_ctrl.sum_en = en[2];

    // Valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en[0])
                valid_pipe_reg[0] <= s_tvalid;
            for (int k = 1; k < 4; k++)
                if (en[k])
                    valid_pipe_reg[k] <= valid_pipe_reg[k-1];
            if (en[4])
                out_valid_reg <= valid_pipe_reg[3];
        end
    end

    // Input stage: scale to 0..999 and derive bold
    always_comb
    begin
        fore_s1_next.red   = scale(s_tdata[7:0]);
        fore_s1_next.green = scale(s_tdata[15:8]);
        fore_s1_next.blue  = scale(s_tdata[23:16]);
        back_s1_next.red   = scale(s_tdata[31:24]);
        back_s1_next.green = scale(s_tdata[39:32]);
        back_s1_next.blue  = scale(s_tdata[47:40]);
        bold_next = (s_tdata[7:0] > npc_pkg::BOLD_LIMIT)
                 || (s_tdata[15:8] > npc_pkg::BOLD_LIMIT)
                 || (s_tdata[23:16] > npc_pkg::BOLD_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fore_s1_reg      <= fore_s1_next;
            back_s1_reg      <= back_s1_next;
            bold_pipe_reg[0] <= bold_next;
        end
        for (int k = 1; k < 4; k++)
            if (en[k])
                bold_pipe_reg[k] <= bold_pipe_reg[k-1];
    end

    // Distance lanes, one per palette entry
    for (genvar g = 0; g < N; g++)
    begin : g_lane
        npc_lane u_lane
        (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .entry     (palette_reg[g]),
            .fore      (fore_s1_reg),
            .back      (back_s1_reg),
            .fore_dist (fore_dist[g]),
            .back_dist (back_dist[g])
        );
    end

    npc_merge u_merge
    (
        .clk        (clk),
        .en         (en[3]),
        .fore_dist  (fore_dist),
        .back_dist  (back_dist),
        .fore_index (fore_index),
        .back_index (back_index)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (en[4])
            out_data_reg <= {bold_pipe_reg[3], back_index, fore_index, back_index, fore_index};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule
